[hw/rtl/lyapunov_exponent_pixel_defines.svh]
// Assertion helpers used by the back end (lep_back).
`ifndef LYAPUNOV_EXPONENT_PIXEL_DEFINES_SVH
`define LYAPUNOV_EXPONENT_PIXEL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LEP_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lep assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LEP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lep assertion failed");

`endif

[hw/rtl/lep_pkg.sv]
package lep_pkg;

   localparam int DIM_W      = 10;
   localparam int PAT_LEN    = 64;
   localparam int POS_W      = 6;
   localparam int LEN_W      = 7;
   localparam int ITER_W     = 13;
   localparam int MAX_ITER   = 4096;
   localparam int EXP_W      = 31;
   localparam int MAXO_W     = 30;
   localparam int SUM_W      = 54;
   localparam int DIV_CNT_W  = 6;
   localparam int FRAC_W     = 26;
   localparam int LOG_INT_W  = 8;
   localparam int LOG_W      = LOG_INT_W + FRAC_W;
   localparam int CSR_IDX_W  = 4;

   // The cap 4.0 in Q3.29 (r) and 1.0 in Q1.31 (x) share the same bit pattern.
   localparam logic [31:0] ONE_Q = 32'h8000_0000;
   localparam logic signed [SUM_W-1:0] LIMIT_Q26 = 54'sd671088640;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_START     = 4'd0,
      CSR_A_STEP      = 4'd1,
      CSR_B_START     = 4'd2,
      CSR_B_STEP      = 4'd3,
      CSR_SEQ_PATTERN = 4'd4,
      CSR_SEQ_LENGTH  = 4'd5,
      CSR_ITERATIONS  = 4'd6,
      CSR_X_START     = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0]       a_start;
      logic [31:0]       a_step;
      logic [31:0]       b_start;
      logic [31:0]       b_step;
      logic [63:0]       seq_pattern;
      logic [LEN_W-1:0]  seq_length;
      logic [ITER_W-1:0] iterations;
      logic [31:0]       x_start;
   } lep_cfg_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        frame_start;
   } lep_item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] f;
   } lep_log_req_type;

endpackage

[hw/rtl/lep_front.sv]
module lep_front import lep_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DIM_W-1:0]  req_column,
   input  logic [DIM_W-1:0]  req_row,
   input  logic              req_frame_start,
   input  lep_cfg_type       cfg,
   input  logic              q_full,
   output logic              q_push,
   output lep_item_type      q_data
);

   logic             stg_valid_ff;
   logic [DIM_W-1:0] stg_col_ff;
   logic [DIM_W-1:0] stg_row_ff;
   logic             stg_fs_ff;
   logic             accept;

   // Saturating axis value: origin plus index times step, capped at 4.0.
   function automatic logic [31:0] axis_value(logic [31:0] start, logic [DIM_W-1:0] idx,
                                              logic [31:0] step);
      logic [42:0] v;
      v = 43'(start) + 43'(idx) * 43'(step);
      return (v > 43'(ONE_Q)) ? ONE_Q : v[31:0];
   endfunction

   assign q_push    = stg_valid_ff && !q_full;
   assign req_stall = stg_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   assign q_data.a           = axis_value(cfg.a_start, stg_col_ff, cfg.a_step);
   assign q_data.b           = axis_value(cfg.b_start, stg_row_ff, cfg.b_step);
   assign q_data.frame_start = stg_fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            stg_valid_ff <= 1'b1;
            stg_col_ff   <= req_column;
            stg_row_ff   <= req_row;
            stg_fs_ff    <= req_frame_start;
         end else if (q_push) begin
            stg_valid_ff <= 1'b0;
         end
      end
   end

endmodule

[hw/rtl/lep_queue.sv]
module lep_queue import lep_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lep_item_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output lep_item_type head
);

   lep_item_type mem_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff         <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[hw/rtl/lep_log2.sv]
module lep_log2 import lep_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lep_log_req_type         req,
   output logic                    done,
   output logic signed [LOG_W-1:0] value
);

   typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQR} lg_state_type;

   lg_state_type        state_ff;
   logic [63:0]         f_ff;
   logic [5:0]          z_ff;
   logic [31:0]         y_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [4:0]          cnt_ff;
   logic                done_ff;
   logic [63:0]         sq;
   logic signed [LOG_INT_W-1:0] int_part;

   assign sq       = 64'(y_ff) * 64'(y_ff);
   assign int_part = 8'sd3 - $signed({2'b00, z_ff});
   assign value    = {int_part, frac_ff};
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            LG_IDLE: begin
               if (req.start) begin
                  f_ff     <= req.f;
                  z_ff     <= 6'd0;
                  state_ff <= LG_NORM;
               end
            end
            LG_NORM: begin
               // Byte steps first, then single bits, until the top bit is set.
               if (f_ff[63:56] == 8'd0) begin
                  f_ff <= {f_ff[55:0], 8'd0};
                  z_ff <= z_ff + 6'd8;
               end else if (!f_ff[63]) begin
                  f_ff <= {f_ff[62:0], 1'b0};
                  z_ff <= z_ff + 6'd1;
               end else begin
                  y_ff     <= f_ff[63:32];
                  cnt_ff   <= 5'd0;
                  state_ff <= LG_SQR;
               end
            end
            LG_SQR: begin
               frac_ff <= {frac_ff[FRAC_W-2:0], sq[63]};
               y_ff    <= sq[63] ? sq[63:32] : sq[62:31];
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(FRAC_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= LG_IDLE;
               end
            end
            default: state_ff <= LG_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/lep_div.sv]
module lep_div import lep_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [ITER_W-1:0]       divisor,
   output logic                    done,
   output logic signed [SUM_W-1:0] quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0]     mag_ff;
   logic [ITER_W-1:0]    rem_ff;
   logic [ITER_W-1:0]    den_ff;
   logic [ITER_W:0]      rem_sh;
   logic                 ge;
   logic [ITER_W:0]      rem_new;

   assign rem_sh   = {rem_ff, mag_ff[SUM_W-1]};
   assign ge       = rem_sh >= {1'b0, den_ff};
   assign rem_new  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
   assign done     = done_ff;

   // Restoring division on the magnitude, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            neg_ff  <= dividend[SUM_W-1];
            mag_ff  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_ff  <= '0;
            den_ff  <= divisor;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_new[ITER_W-1:0];
            mag_ff <= {mag_ff[SUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

[hw/rtl/lep_back.sv]
`include "lyapunov_exponent_pixel_defines.svh"

module lep_back import lep_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lep_cfg_type             cfg,
   input  logic                    q_empty,
   input  lep_item_type            q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [EXP_W-1:0] rsp_exponent,
   output logic signed [EXP_W-1:0] rsp_min_seen,
   output logic [MAXO_W-1:0]       rsp_max_seen
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_LOG, ST_LOGW, ST_DIV, ST_DIVW, ST_FIN
   } state_type;

   state_type                state_ff;
   logic [31:0]              a_ff;
   logic [31:0]              b_ff;
   logic [31:0]              r_ff;
   logic [31:0]              x_ff;
   logic [31:0]              prod_ff;
   logic [63:0]              f_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [ITER_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     zero_ff;
   logic signed [EXP_W-1:0]  expo_ff;
   logic signed [EXP_W-1:0]  min_ff;
   logic signed [EXP_W-1:0]  max_ff;
   logic                     rsp_valid_ff;
   logic signed [EXP_W-1:0]  rsp_exp_ff;
   logic signed [EXP_W-1:0]  rsp_min_ff;
   logic [MAXO_W-1:0]        rsp_max_ff;

   logic [LEN_W-1:0]         len_eff;
   logic [ITER_W-1:0]        iters_eff;
   logic [31:0]              x_init;
   logic [31:0]              r_sel;
   logic                     pos_wrap;
   logic [63:0]              mul1;
   logic [63:0]              mul2;
   logic [34:0]              xn_raw;
   logic [31:0]              xn;
   logic [32:0]              two_x;
   logic [32:0]              d33;
   logic [63:0]              mul3;
   logic                     step_last;
   logic                     out_free;
   lep_log_req_type          log_req;
   logic                     log_done;
   logic signed [LOG_W-1:0]  log_val;
   logic                     div_start;
   logic                     div_done;
   logic signed [SUM_W-1:0]  div_quot;
   logic signed [EXP_W-1:0]  expo_sel;
   logic signed [EXP_W-1:0]  new_min;
   logic signed [EXP_W-1:0]  new_max;

   always_comb begin
      if (cfg.seq_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.seq_length > LEN_W'(PAT_LEN)) begin
         len_eff = LEN_W'(PAT_LEN);
      end else begin
         len_eff = cfg.seq_length;
      end
      if (cfg.iterations == '0) begin
         iters_eff = ITER_W'(1);
      end else if (cfg.iterations > ITER_W'(MAX_ITER)) begin
         iters_eff = ITER_W'(MAX_ITER);
      end else begin
         iters_eff = cfg.iterations;
      end
   end

   assign x_init    = (cfg.x_start > ONE_Q) ? ONE_Q : cfg.x_start;
   assign r_sel     = cfg.seq_pattern[pos_ff] ? b_ff : a_ff;
   assign pos_wrap  = (LEN_W'(pos_ff) + LEN_W'(1)) >= len_eff;
   assign mul1      = 64'(x_ff) * 64'(ONE_Q - x_ff);
   assign mul2      = 64'(r_ff) * 64'(prod_ff);
   assign xn_raw    = mul2[63:29];
   assign xn        = (xn_raw > 35'(ONE_Q)) ? ONE_Q : xn_raw[31:0];
   assign two_x     = {x_ff, 1'b0};
   assign d33       = (two_x >= 33'(ONE_Q)) ? two_x - 33'(ONE_Q) : 33'(ONE_Q) - two_x;
   assign mul3      = 64'(r_ff) * 64'(d33[31:0]);
   assign step_last = (cnt_ff == iters_eff - ITER_W'(1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   assign log_req.start = (state_ff == ST_LOG) && (f_ff != 64'd0);
   assign log_req.f     = f_ff;
   assign div_start     = (state_ff == ST_DIV);

   always_comb begin
      if (zero_ff || div_quot < -LIMIT_Q26) begin
         expo_sel = min_ff;
      end else if (div_quot > LIMIT_Q26) begin
         expo_sel = max_ff;
      end else begin
         expo_sel = div_quot[EXP_W-1:0];
      end
      new_min = (expo_ff < min_ff) ? expo_ff : min_ff;
      new_max = (expo_ff > max_ff) ? expo_ff : max_ff;
   end

   lep_log2 u_log2 (
      .clock (clock),
      .reset (reset),
      .req   (log_req),
      .done  (log_done),
      .value (log_val)
   );

   lep_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (iters_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the final state the response register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  a_ff    <= q_head.a;
                  b_ff    <= q_head.b;
                  x_ff    <= x_init;
                  pos_ff  <= '0;
                  cnt_ff  <= '0;
                  sum_ff  <= '0;
                  zero_ff <= 1'b0;
                  if (q_head.frame_start) begin
                     min_ff <= '0;
                     max_ff <= '0;
                  end
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               prod_ff  <= mul1[62:31];
               r_ff     <= r_sel;
               pos_ff   <= pos_wrap ? '0 : pos_ff + 1'b1;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               x_ff     <= xn;
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               f_ff     <= mul3;
               state_ff <= ST_LOG;
            end
            ST_LOG: begin
               if (f_ff == 64'd0) begin
                  zero_ff <= 1'b1;
                  if (step_last) begin
                     state_ff <= ST_DIV;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= ST_MUL1;
                  end
               end else begin
                  state_ff <= ST_LOGW;
               end
            end
            ST_LOGW: begin
               if (log_done) begin
                  sum_ff <= sum_ff + SUM_W'(log_val);
                  if (step_last) begin
                     state_ff <= ST_DIV;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= ST_MUL1;
                  end
               end
            end
            ST_DIV: begin
               state_ff <= ST_DIVW;
            end
            ST_DIVW: begin
               if (div_done) begin
                  expo_ff  <= expo_sel;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_exp_ff   <= expo_ff;
                  rsp_min_ff   <= new_min;
                  rsp_max_ff   <= new_max[MAXO_W-1:0];
                  min_ff       <= new_min;
                  max_ff       <= new_max;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_exponent = rsp_exp_ff;
   assign rsp_min_seen = rsp_min_ff;
   assign rsp_max_seen = rsp_max_ff;

   `LEP_ASSERT_SAME(a_log_done_in_wait, clock, reset, log_done, state_ff == ST_LOGW)
   `LEP_ASSERT_SAME(a_div_done_in_wait, clock, reset, div_done, state_ff == ST_DIVW)
   `LEP_ASSERT_SAME(a_running_signs, clock, reset, 1'b1, !(min_ff > 31'sd0) && !(max_ff < 31'sd0))
   `LEP_ASSERT_NEXT(a_fin_emits, clock, reset, (state_ff == ST_FIN) && out_free, rsp_valid_ff)

endmodule

[hw/rtl/lyapunov_exponent_pixel.sv]
// Lyapunov fractal pixel engine. Each request word carries a pixel column and row; the block
// maps them to the two logistic-map rates a and b (Q3.29, capped at 4.0), runs the map
// x = r*x*(1-x) for the programmed number of steps with r picked from the A/B pattern,
// averages log2|r*(1-2x)| and returns one response word with the exponent (signed Q5.26)
// and the running minimum and maximum of the frame. Results below -10, or any pixel that
// hit a zero factor, report the running minimum; results above 10 report the running
// maximum. A word with frame_start set clears both running values before it is processed.
// Per map step the three multiplies run in states MUL1 to MUL3 and a zero check follows in
// state LOG; a step with a zero factor ends there. Otherwise the log2 unit normalizes the
// factor, first by bytes and then by single bits, then squares once per fraction bit and
// hands its result back. At the end a bit-serial divider forms the average. The back end
// picks up the pixel, iterates, starts the divide, collects the quotient and, once the
// previous response no longer waits on the output, loads the response register. The front
// end computes the axis values and parks up to two pixels in a queue, so new request words
// are taken while a pixel is being iterated, and a finished response waits in its own
// register without holding up the next pixel. Configuration writes are always accepted
// (csr_ready is tied high) and must only be issued while the block is idle.
module lyapunov_exponent_pixel import lep_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [DIM_W-1:0]        req_column,
   input  logic [DIM_W-1:0]        req_row,
   input  logic                    req_frame_start,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [EXP_W-1:0] rsp_exponent,
   output logic signed [EXP_W-1:0] rsp_min_seen,
   output logic [MAXO_W-1:0]       rsp_max_seen,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]             csr_data
);

   lep_cfg_type  cfg_ff;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   lep_item_type q_in;
   lep_item_type q_head;

   assign csr_ready = 1'b1;

   // Register file; indexes outside the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_start     <= 32'd0;
         cfg_ff.a_step      <= 32'd2097152;
         cfg_ff.b_start     <= 32'd0;
         cfg_ff.b_step      <= 32'd2097152;
         cfg_ff.seq_pattern <= 64'd2;
         cfg_ff.seq_length  <= 7'd2;
         cfg_ff.iterations  <= 13'd1000;
         cfg_ff.x_start     <= 32'h4000_0000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_A_START:     cfg_ff.a_start     <= csr_data[31:0];
            CSR_A_STEP:      cfg_ff.a_step      <= csr_data[31:0];
            CSR_B_START:     cfg_ff.b_start     <= csr_data[31:0];
            CSR_B_STEP:      cfg_ff.b_step      <= csr_data[31:0];
            CSR_SEQ_PATTERN: cfg_ff.seq_pattern <= csr_data;
            CSR_SEQ_LENGTH:  cfg_ff.seq_length  <= csr_data[LEN_W-1:0];
            CSR_ITERATIONS:  cfg_ff.iterations  <= csr_data[ITER_W-1:0];
            CSR_X_START:     cfg_ff.x_start     <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   // Front end: takes the request word and computes the two axis rates.
   lep_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_row         (req_row),
      .req_frame_start (req_frame_start),
      .cfg             (cfg_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_in)
   );

   // Two-entry queue decoupling the front end from the iteration engine.
   lep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Back end: map iteration, log accumulation, averaging and clamping.
   lep_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_exponent (rsp_exponent),
      .rsp_min_seen (rsp_min_seen),
      .rsp_max_seen (rsp_max_seen)
   );

endmodule
